FILE: rtl/nnds_pkg.sv
// Shared types, codes and constants for the nearest node distance search.
package nnds_pkg;

    localparam int unsigned MaxNodesDefault = 256;
    localparam int unsigned CoordW = 32;
    localparam int unsigned DiffW = CoordW + 1;
    localparam int unsigned SqW = 2 * DiffW;
    localparam int unsigned DistW = 33;
    localparam logic [DistW-1:0] DistLimit = 33'd6553600000;

    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdAdd = 2'd1;
    localparam logic [1:0] CmdQuery = 2'd2;
    localparam logic [1:0] CmdSpare = 2'd3;

    localparam logic [1:0] StatOk = 2'd0;
    localparam logic [1:0] StatFull = 2'd1;
    localparam logic [1:0] StatNoMatch = 2'd2;

    localparam logic [1:0] FiltAll = 2'd0;
    localparam logic [1:0] FiltFree = 2'd1;
    localparam logic [1:0] FiltObst = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic obstacle_mark;
    } t_in;

    typedef struct packed {
        logic [DistW-1:0] near_dist;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic obs;
    } t_node;

endpackage

FILE: rtl/nearest_node_distance_search.sv
// Top level: node ring, scan control, distance pipeline, square root and result register.
//
//  channel | direction | handshake             | word
//  in      | input     | i_in_valid/o_in_ready | command, pos_x, pos_y, obstacle_mark
//  out     | output    | o_out_valid/i_out_ready | near_dist, status
//  cfg     | input     | i_cfg_valid/o_cfg_ready | filter_mode
//
// A query rotates the node ring once, one node per cycle, then drains the distance
// pipeline, runs the square root and registers the result word.
// Reset empties the table and sets the filter mode to all nodes.
// A new word is taken only while no query is running and the result register is
// free or being emptied in the same cycle.
module nearest_node_distance_search #(
    parameter int unsigned MAX_NODES = nnds_pkg::MaxNodesDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  nnds_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output nnds_pkg::t_out   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam int unsigned KW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned DrainCycles = 3;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_ROOT, S_WAIT, S_DONE} t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [KW-1:0] r_k;
    logic [1:0] r_drain;
    logic [1:0] r_filter;
    logic signed [nnds_pkg::CoordW-1:0] r_px, r_py;
    logic r_out_valid;
    nnds_pkg::t_out r_out;
    logic [nnds_pkg::DistW-1:0] r_root;

    nnds_pkg::t_node w_node [MAX_NODES];
    nnds_pkg::t_node w_head, w_feed;
    logic w_shift, w_accept, w_out_free, w_valid_node, w_match, w_found;
    logic w_root_done, w_set_valid;
    logic [nnds_pkg::SqW-1:0] w_best;
    logic [nnds_pkg::DistW-1:0] w_root;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_head = w_node[MAX_NODES-1];
    assign w_set_valid = (w_accept && i_in_data.command != nnds_pkg::CmdQuery) ||
                         (r_state == S_DONE && w_out_free);

    // New nodes enter at the first cell; during a query the ring rotates one full turn.
    assign w_shift = (r_state == S_SCAN) ||
                     (w_accept && i_in_data.command == nnds_pkg::CmdAdd &&
                      r_count != CW'(MAX_NODES));
    assign w_feed = (r_state == S_SCAN) ? w_head :
                    nnds_pkg::t_node'{x: i_in_data.pos_x, y: i_in_data.pos_y,
                                      obs: i_in_data.obstacle_mark};

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++) begin : g_ring
            if (g == 0) begin : g_first
                nnds_cell u_cell (.i_clk(i_clk), .i_shift(w_shift), .i_node(w_feed),
                                  .o_node(w_node[g]));
            end else begin : g_rest
                nnds_cell u_cell (.i_clk(i_clk), .i_shift(w_shift), .i_node(w_node[g-1]),
                                  .o_node(w_node[g]));
            end
        end
    endgenerate

    // The head cell at scan step k holds slot MAX_NODES-1-k, which is filled
    // when that slot lies below the node count.
    assign w_valid_node = ({1'b0, CW'(r_k)} + {1'b0, r_count}) >= (CW + 1)'(MAX_NODES);
    always_comb begin
        case (r_filter)
            nnds_pkg::FiltAll:  w_match = 1'b1;
            nnds_pkg::FiltFree: w_match = !w_head.obs;
            nnds_pkg::FiltObst: w_match = w_head.obs;
            default:            w_match = 1'b0;
        endcase
    end

    nnds_dist u_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_clear(w_accept),
        .i_valid((r_state == S_SCAN) && w_valid_node && w_match),
        .i_node(w_head), .i_px(r_px), .i_py(r_py),
        .o_found(w_found), .o_best(w_best)
    );

    nnds_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_DRAIN && r_drain == 2'(DrainCycles - 1)),
        .i_rad(w_best), .o_done(w_root_done), .o_root(w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_filter <= nnds_pkg::FiltAll;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_filter <= i_cfg_data;
            end
            if (w_set_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out.near_dist <= '0;
                        case (i_in_data.command)
                            nnds_pkg::CmdClear: begin
                                r_count <= '0;
                                r_out.status <= nnds_pkg::StatOk;
                            end
                            nnds_pkg::CmdAdd: begin
                                if (r_count == CW'(MAX_NODES)) begin
                                    r_out.status <= nnds_pkg::StatFull;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    r_out.status <= nnds_pkg::StatOk;
                                end
                            end
                            nnds_pkg::CmdQuery: begin
                                r_state <= S_SCAN;
                                r_out.status <= nnds_pkg::StatOk;
                            end
                            default: begin
                                r_out.status <= nnds_pkg::StatOk;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_k == KW'(MAX_NODES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == 2'(DrainCycles - 1)) begin
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        if (!w_found) begin
                            r_out.near_dist <= nnds_pkg::DistLimit;
                            r_out.status <= nnds_pkg::StatNoMatch;
                        end else begin
                            r_out.near_dist <= (r_root < nnds_pkg::DistLimit) ?
                                               r_root : nnds_pkg::DistLimit;
                            r_out.status <= nnds_pkg::StatOk;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_px <= i_in_data.pos_x;
            r_py <= i_in_data.pos_y;
            r_k <= '0;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + 1'b1;
        end
        if (r_state == S_DRAIN) begin
            r_drain <= r_drain + 1'b1;
        end else begin
            r_drain <= '0;
        end
        if (w_root_done) begin
            r_root <= w_root;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

FILE: rtl/nnds_cell.sv
// One node cell of the storage ring: holds a node and passes it on when shifted.
module nnds_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  nnds_pkg::t_node i_node,
    output nnds_pkg::t_node o_node
);

    nnds_pkg::t_node r_node;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_node <= i_node;
        end
    end

    assign o_node = r_node;

endmodule

FILE: rtl/nnds_dist.sv
// Squared distance pipeline with a running minimum over the scanned nodes.
module nnds_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic                                i_valid,
    input  nnds_pkg::t_node                     i_node,
    input  logic signed [nnds_pkg::CoordW-1:0]  i_px,
    input  logic signed [nnds_pkg::CoordW-1:0]  i_py,
    output logic                                o_found,
    output logic [nnds_pkg::SqW-1:0]            o_best
);

    localparam int unsigned DW = nnds_pkg::DiffW;
    localparam int unsigned SW = nnds_pkg::SqW;

    logic r_va, r_vb;
    logic [DW-1:0] r_dx, r_dy;
    logic [SW-1:0] r_sx, r_sy;
    logic r_found;
    logic [SW-1:0] r_best;
    logic signed [DW-1:0] n_ddx, n_ddy;
    logic [DW-1:0] n_dx, n_dy;
    logic [SW-1:0] n_sum;

    always_comb begin
        n_ddx = DW'(i_node.x) - DW'(i_px);
        n_ddy = DW'(i_node.y) - DW'(i_py);
        n_dx = n_ddx[DW-1] ? DW'(-n_ddx) : DW'(n_ddx);
        n_dy = n_ddy[DW-1] ? DW'(-n_ddy) : DW'(n_ddy);
        n_sum = r_sx + r_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            if (r_vb && (!r_found || n_sum < r_best)) begin
                r_found <= 1'b1;
            end
        end
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_sx <= SW'(r_dx) * SW'(r_dx);
        r_sy <= SW'(r_dy) * SW'(r_dy);
        if (r_vb && (!r_found || n_sum < r_best)) begin
            r_best <= n_sum;
        end
    end

    assign o_found = r_found;
    assign o_best = r_best;

endmodule

FILE: rtl/nnds_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module nnds_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [nnds_pkg::SqW-1:0]          i_rad,
    output logic                              o_done,
    output logic [nnds_pkg::DistW-1:0]        o_root
);

    localparam int unsigned RW = nnds_pkg::DistW;
    localparam int unsigned SW = nnds_pkg::SqW;
    localparam int unsigned MW = RW + 3;
    localparam int unsigned CW = $clog2(RW + 1);

    logic r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rad;
    logic [MW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [MW-1:0] n_rem, n_trial;

    always_comb begin
        n_rem = {r_rem[MW-3:0], r_rad[SW-1:SW-2]};
        n_trial = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(RW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= '0;
            r_rad <= i_rad;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rad <= {r_rad[SW-3:0], 2'b00};
            if (n_rem >= n_trial) begin
                r_rem <= n_rem - n_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
